>>> rtl/core/utf8_math_style_transcoder_defines.svh
// Assertion macros used by the transcoder top level
`ifndef UTF8_MATH_STYLE_TRANSCODER_DEFINES_SVH
`define UTF8_MATH_STYLE_TRANSCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define UMST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define UMST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/umst_pkg.sv
// Types, constants and mapping/encoding functions for the UTF-8 math style transcoder
package umst_pkg;

  // Configuration port
  localparam int PADDR_W = 1;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_STYLE_MODE = 1'b0;

  // Style codes
  localparam logic [1:0] STYLE_NONE        = 2'd0;
  localparam logic [1:0] STYLE_BOLD        = 2'd1;
  localparam logic [1:0] STYLE_ITALIC      = 2'd2;
  localparam logic [1:0] STYLE_BOLD_ITALIC = 2'd3;

  // Code point targets
  localparam logic [20:0] CP_BOLD_UP     = 21'h1D400;
  localparam logic [20:0] CP_BOLD_LO     = 21'h1D41A;
  localparam logic [20:0] CP_BOLD_DIGIT  = 21'h1D7CE;
  localparam logic [20:0] CP_BI_UP       = 21'h1D468;
  localparam logic [20:0] CP_BI_LO       = 21'h1D482;
  localparam logic [20:0] CP_IT_UP       = 21'h1D434;
  localparam logic [20:0] CP_IT_LO       = 21'h1D44E;
  localparam logic [20:0] CP_IT_SMALL_H  = 21'h0210E;
  localparam logic [20:0] CP_ASCII_UP_A  = 21'h41;
  localparam logic [20:0] CP_ASCII_UP_Z  = 21'h5A;
  localparam logic [20:0] CP_ASCII_LO_A  = 21'h61;
  localparam logic [20:0] CP_ASCII_LO_Z  = 21'h7A;
  localparam logic [20:0] CP_ASCII_LO_H  = 21'h68;
  localparam logic [20:0] CP_ASCII_D0    = 21'h30;
  localparam logic [20:0] CP_ASCII_D9    = 21'h39;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } out_t;

  typedef struct packed {
    logic [20:0] cp;
    logic        raw;
    logic        last;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    logic     idle;
    q_entry_t entry;
  } fe_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt;
  } enc_t;

  // Map a code point to its mathematical style
  function automatic logic [20:0] map_style(input logic [20:0] cp, input logic [1:0] mode);
    logic        up;
    logic        lo;
    logic        dig;
    logic [20:0] res;
    up  = (cp >= CP_ASCII_UP_A) && (cp <= CP_ASCII_UP_Z);
    lo  = (cp >= CP_ASCII_LO_A) && (cp <= CP_ASCII_LO_Z);
    dig = (cp >= CP_ASCII_D0) && (cp <= CP_ASCII_D9);
    res = cp;
    case (mode)
      STYLE_BOLD: begin
        if (up) res = CP_BOLD_UP + (cp - CP_ASCII_UP_A);
        else if (lo) res = CP_BOLD_LO + (cp - CP_ASCII_LO_A);
        else if (dig) res = CP_BOLD_DIGIT + (cp - CP_ASCII_D0);
      end
      STYLE_ITALIC: begin
        if (up) res = CP_IT_UP + (cp - CP_ASCII_UP_A);
        else if (lo && cp == CP_ASCII_LO_H) res = CP_IT_SMALL_H;
        else if (lo) res = CP_IT_LO + (cp - CP_ASCII_LO_A);
      end
      STYLE_BOLD_ITALIC: begin
        if (up) res = CP_BI_UP + (cp - CP_ASCII_UP_A);
        else if (lo) res = CP_BI_LO + (cp - CP_ASCII_LO_A);
        else if (dig) res = CP_BOLD_DIGIT + (cp - CP_ASCII_D0);
      end
      default: res = cp;
    endcase
    return res;
  endfunction

  // Shortest-form UTF-8 encoding; cnt holds the byte count minus one
  function automatic enc_t encode_cp(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.cnt      = 2'd0;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.cnt      = 2'd1;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.cnt      = 2'd2;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.cnt      = 2'd3;
    end
    return e;
  endfunction

endpackage

>>> rtl/core/umst_front.sv
// Front end: accepts input bytes and decodes UTF-8 sequences into code points
module umst_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  umst_pkg::in_t   data,
  output umst_pkg::fe_stat_t stat
);
  import umst_pkg::*;

  logic [20:0] acc;
  logic [1:0]  rem;
  logic [20:0] acc_mid;
  logic [1:0]  rem_mid;
  logic [20:0] acc_next;
  logic [1:0]  rem_next;
  logic        done;
  logic        raw;
  logic [7:0]  b;

  assign b = data.in_byte;

  // Classify the byte and gather code point bits
  always_comb begin
    acc_mid = acc;
    rem_mid = rem;
    done    = 1'b0;
    raw     = 1'b0;
    if (rem == 2'd0) begin
      if (b[7] == 1'b0) begin
        acc_mid = {13'b0, b};
        done    = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        acc_mid = {16'b0, b[4:0]};
        rem_mid = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_mid = {17'b0, b[3:0]};
        rem_mid = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc_mid = {18'b0, b[2:0]};
        rem_mid = 2'd3;
      end else begin
        raw = 1'b1;
      end
    end else begin
      acc_mid = {acc[14:0], b[5:0]};
      rem_mid = rem - 2'd1;
      done    = (rem == 2'd1);
    end

    // Close an open sequence at the end of the text, padding with zeros
    acc_next = acc_mid;
    rem_next = rem_mid;
    if (data.in_last && rem_mid != 2'd0) begin
      case (rem_mid)
        2'd1:    acc_next = {acc_mid[14:0], 6'b0};
        2'd2:    acc_next = {acc_mid[8:0], 12'b0};
        2'd3:    acc_next = {acc_mid[2:0], 18'b0};
        default: acc_next = acc_mid;
      endcase
      rem_next = 2'd0;
      done     = 1'b1;
    end
  end

  // Advance decoder state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      rem <= '0;
    end else if (accept) begin
      rem <= rem_next;
      acc <= done ? 21'd0 : acc_next;
    end
  end

  assign stat.push       = accept && (done || raw);
  assign stat.idle       = (rem == 2'd0);
  assign stat.entry.cp   = raw ? {13'b0, b} : acc_next;
  assign stat.entry.raw  = raw;
  assign stat.entry.last = data.in_last;

endmodule

>>> rtl/core/umst_queue.sv
// Short queue of decoded code points between front and back end
module umst_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  umst_pkg::q_entry_t   wr_entry,
  input  logic                 pop,
  output umst_pkg::q_entry_t   head,
  output umst_pkg::q_stat_t    stat
);
  import umst_pkg::*;

  q_entry_t           mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

endmodule

>>> rtl/core/umst_back.sv
// Back end: maps code points to the selected style and emits UTF-8 bytes
module umst_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         style_mode,
  input  umst_pkg::q_entry_t head,
  input  umst_pkg::q_stat_t  qstat,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_stall,
  output umst_pkg::out_t     res_data
);
  import umst_pkg::*;

  logic            cur_valid;
  logic [3:0][7:0] cur_bytes;
  logic [1:0]      cur_cnt;
  logic [1:0]      cur_idx;
  logic            cur_last;
  logic            adv;
  logic            emit;
  logic            cur_done;
  logic [20:0]     mapped;
  enc_t            enc;

  assign adv      = !res_valid || !res_stall;
  assign emit     = adv && cur_valid;
  assign cur_done = emit && (cur_idx == cur_cnt);
  assign pop      = (!cur_valid || cur_done) && !qstat.empty;

  // Map and encode the queue head; a copied byte bypasses both
  always_comb begin
    mapped = map_style(head.cp, style_mode);
    enc    = encode_cp(mapped);
    if (head.raw) begin
      enc          = '0;
      enc.bytes[0] = head.cp[7:0];
      enc.cnt      = 2'd0;
    end
  end

  // Hold the encoded sequence being sent
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (cur_done) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_bytes <= enc.bytes;
      cur_cnt   <= enc.cnt;
      cur_idx   <= 2'd0;
      cur_last  <= head.last;
    end else if (emit) begin
      cur_idx <= cur_idx + 2'd1;
    end
  end

  // Output register: advance when empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_data.out_byte <= cur_bytes[cur_idx];
      res_data.run_last <= (cur_idx == cur_cnt);
      res_data.text_end <= (cur_idx == cur_cnt) && cur_last;
    end
  end

endmodule

>>> rtl/core/utf8_math_style_transcoder.sv
// Top level of the UTF-8 math style transcoder
// Takes UTF-8 text one byte per transfer and gives re-encoded UTF-8 bytes, with ASCII
// letters (and, in the bold modes, digits) turned into mathematical bold, italic or
// bold-italic forms as style_mode selects (register 0, byte address 0). The input
// side takes one byte per cycle while the four-entry code point queue has room; the
// output side sends one byte per cycle unless res_stall holds it, so each code point
// yields as many output bytes as its encoded length, one to four. A byte that starts
// or continues a sequence gives no output unless it finishes it or ends the text.
// Write style_mode only while no text is in flight.
module utf8_math_style_transcoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_valid,
  output logic                           byte_stall,
  input  umst_pkg::in_t                  byte_data,
  output logic                           res_valid,
  input  logic                           res_stall,
  output umst_pkg::out_t                 res_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [umst_pkg::PADDR_W-1:0]   paddr,
  input  logic [umst_pkg::PDATA_W-1:0]   pwdata,
  output logic [umst_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import umst_pkg::*;

`include "utf8_math_style_transcoder_defines.svh"

  logic       style_mode;
  logic [1:0] style;
  logic       accept;
  logic       pop;
  fe_stat_t   fe_stat;
  q_stat_t    q_stat;
  q_entry_t   head;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      style <= STYLE_NONE;
    end else if (psel && penable && pwrite && paddr == ADDR_STYLE_MODE) begin
      style <= pwdata[1:0];
    end
  end

  assign prdata     = (paddr == ADDR_STYLE_MODE) ? {{(PDATA_W-2){1'b0}}, style} : '0;
  assign style_mode = (style != STYLE_NONE);

  // Input transfer while the queue has room
  assign byte_stall = q_stat.full;
  assign accept     = byte_valid && !byte_stall;

  umst_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .data   (byte_data),
    .stat   (fe_stat)
  );

  umst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fe_stat.push),
    .wr_entry (fe_stat.entry),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  umst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .style_mode (style),
    .head       (head),
    .qstat      (q_stat),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

  // The queue never takes an entry it has no room for
  `UMST_ASSERT_NOW(a_no_overflow, clk, rst, fe_stat.push, !q_stat.full, "queue overflow")
  // The last byte of the text leaves the decoder with no open sequence
  `UMST_ASSERT_NEXT(a_end_idle, clk, rst, accept && byte_data.in_last, fe_stat.idle,
    "sequence left open after end of text")
  // End of text only on the final byte of a run
  `UMST_ASSERT_NOW(a_end_run, clk, rst, res_valid && res_data.text_end, res_data.run_last,
    "text end without run end")
  // The style-active flag is clear when the style register holds STYLE_NONE
  `UMST_ASSERT_NOW(a_style_flag, clk, rst, style == STYLE_NONE, !style_mode,
    "style flag mismatch")

endmodule
